// ===== rtl/bmw_pkg.sv =====
// shared constants, types and codes for the binary morphology window unit
`timescale 1ns / 1ps
`default_nettype none

package bmw_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);

    localparam int PIXEL_W    = 8;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 16;
    localparam int IN_ROW_W   = IMG_H_W + 1;   // drain rows run past the last image row
    localparam int MODE_W     = 2;
    localparam int KINDS_W    = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_OPERATION_MODE = 2'd2,
        REG_CELL_KINDS     = 2'd3
    } reg_index_t;

    localparam logic [MODE_W-1:0] MODE_DILATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd1;

    typedef logic [1:0] flags_t;

    localparam flags_t FLAG_WHITE = 2'b01;
    localparam flags_t FLAG_BLACK = 2'b10;
    localparam flags_t KIND_WHITE = 2'b01;
    localparam flags_t KIND_BLACK = 2'b10;

    localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'hFF;
    localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'h00;

    typedef struct packed {
        flags_t newer;
        flags_t older;
    } line_entry_t;

    typedef struct packed {
        logic row_first;
        logic row_last;
        logic col_first;
        logic col_last;
    } border_t;

    typedef struct packed {
        logic               frame_last;
        logic [PIXEL_W-1:0] result_pixel;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/bmw_ram.sv =====
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bmw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bmw_out_queue.sv =====
// small result queue between the window logic and the output channel
`timescale 1ns / 1ps
`default_nettype none

module bmw_out_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire bmw_pkg::out_word_t            push_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bmw_pkg::out_word_t                 out_word,
    output logic [bmw_pkg::OUT_LEVEL_W-1:0]    level
);

    import bmw_pkg::*;

    out_word_t              entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_LEVEL_W-1:0] level_reg, level_next;
    logic                   pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_word  = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/binary_morphology_window_unit.sv =====
// top level: 3x3 binary morphology (dilate, erode, hit-or-miss) on a raster pixel stream
//
// One word is taken per clock while s_axis_tready is high. Each pixel is reduced to
// white (255) and black (0) flags; the two previous rows sit in one line ram of
// MAX_WIDTH entries, read in the cycle a word is taken and written back in the next
// cycle, with a bypass for a write to the same column. The stream of results lags the
// input by one row plus one pixel, so a frame needs image_width + 1 drain words (tuser
// high) after its last pixel; drain words before the frame end are dropped.
// s_axis_tready falls only when the four-word result queue could be overrun.
// Configuration must be written only between frames; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_window_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bmw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmw_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,   // pixel_value
    input  wire logic                            s_axis_tuser,   // drain
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,   // result_pixel
    output logic                                 m_axis_tlast    // frame_last
);

    import bmw_pkg::*;

    // configuration
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [MODE_W-1:0]  operation_mode_reg;
    logic [KINDS_W-1:0] cell_kinds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= IMG_W_W'(1);
            image_height_reg   <= IMG_H_W'(1);
            operation_mode_reg <= MODE_DILATE;
            cell_kinds_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_wr_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_wr_data[IMG_H_W-1:0];
                REG_OPERATION_MODE: operation_mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_CELL_KINDS:     cell_kinds_reg     <= cfg_wr_data[KINDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [IMG_W_W-1:0] w_eff;
    logic [IMG_H_W-1:0] h_eff;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = IMG_W_W'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_eff = IMG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        h_eff = (image_height_reg == '0) ? IMG_H_W'(1) : image_height_reg;
    end

    // input side: position counters and word classification
    logic [LINE_ADDR_W-1:0] in_column_reg, in_column_next;
    logic [IN_ROW_W-1:0]    in_row_reg, in_row_next;
    logic [LINE_ADDR_W-1:0] out_column_reg, out_column_next;
    logic [IMG_H_W-1:0]     out_row_reg, out_row_next;

    logic                   s_accept;
    logic                   take;
    logic                   frame_open;
    flags_t                 pixel_flags;
    logic                   in_wrap;
    logic                   out_wrap;
    logic                   out_row_end;
    logic                   emit0;
    logic                   last0;
    border_t                border0;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign frame_open = 32'(in_row_reg) < 32'(h_eff);
    assign take       = s_accept && !(s_axis_tuser && frame_open);

    always_comb begin
        if (!frame_open) begin
            pixel_flags = FLAG_BLACK;
        end else if (s_axis_tdata == PIXEL_WHITE) begin
            pixel_flags = FLAG_WHITE;
        end else if (s_axis_tdata == PIXEL_BLACK) begin
            pixel_flags = FLAG_BLACK;
        end else begin
            pixel_flags = '0;
        end
    end

    assign in_wrap     = (32'(in_column_reg) + 32'd1) >= 32'(w_eff);
    assign out_wrap    = (32'(out_column_reg) + 32'd1) >= 32'(w_eff);
    assign out_row_end = (32'(out_row_reg) + 32'd1) >= 32'(h_eff);
    assign emit0       = (in_row_reg > IN_ROW_W'(1))
                      || ((in_row_reg == IN_ROW_W'(1)) && (in_column_reg != '0));
    assign last0       = out_wrap && out_row_end;

    always_comb begin
        border0.row_first = (out_row_reg == '0);
        border0.row_last  = out_row_end;
        border0.col_first = (out_column_reg == '0);
        border0.col_last  = out_wrap;
    end

    always_comb begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (take) begin
            if (in_wrap) begin
                in_column_next = '0;
                in_row_next    = in_row_reg + 1'b1;
            end else begin
                in_column_next = in_column_reg + 1'b1;
            end
            if (emit0) begin
                if (out_wrap) begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + 1'b1;
                end else begin
                    out_column_next = out_column_reg + 1'b1;
                end
                if (last0) begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end else begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // window stage
    logic                   v1_reg;
    flags_t                 f1_reg;
    logic [LINE_ADDR_W-1:0] col1_reg;
    logic                   emit1_reg;
    logic                   last1_reg;
    border_t                border1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f1_reg      <= pixel_flags;
            col1_reg    <= in_column_reg;
            emit1_reg   <= emit0;
            last1_reg   <= last0;
            border1_reg <= border0;
        end
    end

    line_entry_t            ram_rd_data;
    line_entry_t            line_entry;
    line_entry_t            line_wr_data;
    logic                   fwd_valid_reg;
    logic [LINE_ADDR_W-1:0] fwd_addr_reg;
    line_entry_t            fwd_data_reg;

    bmw_ram #(
        .WIDTH ($bits(line_entry_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (v1_reg),
        .wr_addr (col1_reg),
        .wr_data (line_wr_data),
        .rd_addr (in_column_reg),
        .rd_data (ram_rd_data)
    );

    // write in the cycle of the read is not yet seen by the ram output
    assign line_entry = (fwd_valid_reg && (fwd_addr_reg == col1_reg)) ? fwd_data_reg
                                                                      : ram_rd_data;

    always_comb begin
        line_wr_data.newer = f1_reg;
        line_wr_data.older = line_entry.newer;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= col1_reg;
        fwd_data_reg <= line_wr_data;
    end

    // window_reg[column][row], column 0 left, row 0 top
    flags_t window_reg  [3][3];
    flags_t window_next [3][3];

    always_comb begin
        window_next[0]    = window_reg[1];
        window_next[1]    = window_reg[2];
        window_next[2][0] = line_entry.older;
        window_next[2][1] = line_entry.newer;
        window_next[2][2] = f1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '{default: '0};
        end else if (v1_reg) begin
            window_reg <= window_next;
        end
    end

    logic any_hit;
    logic all_hit;
    logic any_outside;
    logic result_white;

    always_comb begin
        flags_t kind;
        flags_t cell_flags;
        logic   in_image;
        logic   hit;
        any_hit     = 1'b0;
        all_hit     = 1'b1;
        any_outside = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                kind     = cell_kinds_reg[2*(3*r+c) +: 2];
                in_image = !((r == 0) && border1_reg.row_first)
                        && !((r == 2) && border1_reg.row_last)
                        && !((c == 0) && border1_reg.col_first)
                        && !((c == 2) && border1_reg.col_last);
                cell_flags = in_image ? window_next[c][r] : FLAG_BLACK;
                hit        = |(cell_flags & kind);
                if ((kind == KIND_WHITE) || (kind == KIND_BLACK)) begin
                    if (hit) begin
                        any_hit = 1'b1;
                    end else begin
                        all_hit = 1'b0;
                    end
                    if (!in_image) begin
                        any_outside = 1'b1;
                    end
                end
            end
        end
        case (operation_mode_reg)
            MODE_DILATE: result_white = any_hit;
            MODE_ERODE:  result_white = all_hit;
            default:     result_white = all_hit && !any_outside;
        endcase
    end

    // result queue
    logic                   push;
    out_word_t              push_word;
    out_word_t              out_word;
    logic [OUT_LEVEL_W-1:0] out_level;

    assign push                   = v1_reg && emit1_reg;
    assign push_word.result_pixel = result_white ? PIXEL_WHITE : PIXEL_BLACK;
    assign push_word.frame_last   = last1_reg;

    bmw_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word),
        .level     (out_level)
    );

    assign s_axis_tready = (32'(out_level) + 32'(v1_reg)) < OUT_DEPTH;
    assign m_axis_tdata  = out_word.result_pixel;
    assign m_axis_tlast  = out_word.frame_last;

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (32'(out_level) < OUT_DEPTH))
        else $error("result queue overrun");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && emit0 && last0) |=> (in_column_reg == '0) && (in_row_reg == '0)
            && (out_column_reg == '0) && (out_row_reg == '0))
        else $error("counters not cleared after frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == PIXEL_WHITE) || (m_axis_tdata == PIXEL_BLACK))
        else $error("result word neither white nor black");

endmodule

`default_nettype wire

// ===== sim/tb_binary_morphology_window_unit.sv =====
// testbench for the binary morphology window unit: random raster frames against a predictor
`timescale 1ns / 1ps

module tb_binary_morphology_window_unit;

    import bmw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_HIT_MISS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned RANDOM_WORDS = 1750;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               drain;
    } in_word_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    reg_index_t            cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // pixel_value
    logic                  s_axis_tuser  = 1'b0; // drain
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // result_pixel
    logic                  m_axis_tlast;         // frame_last

    binary_morphology_window_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor copy of the registers and the window state
    logic [IMG_W_W-1:0] cfg_width  = 12'd1;
    logic [IMG_H_W-1:0] cfg_height = 16'd1;
    logic [MODE_W-1:0]  cfg_mode   = MODE_DILATE;
    logic [KINDS_W-1:0] cfg_cells  = '0;
    flags_t             older_row [MAX_WIDTH];
    flags_t             newer_row [MAX_WIDTH];
    flags_t             win [3][3];            // [slot left..right][row top..bottom]
    int unsigned        in_col  = 0;
    int unsigned        in_row  = 0;
    int unsigned        out_col = 0;
    int unsigned        out_row = 0;

    in_word_t    pixel_queue[$];
    out_word_t   pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned fed_items      = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_gap       = 0;
    int unsigned hold_left      = 0;
    bit          hold_armed     = 1'b0;
    bit          hold_served    = 1'b0;
    bit          calm           = 1'b0;

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int s = 0; s < 3; s++) begin
            for (int r = 0; r < 3; r++) begin
                win[s][r] = '0;
            end
        end
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned span_cols();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned span_rows();
        return (cfg_height == 0) ? 1 : 32'(cfg_height);
    endfunction

    function automatic flags_t pixel_flags(logic [PIXEL_W-1:0] pix);
        if (pix == PIXEL_WHITE) return FLAG_WHITE;
        if (pix == PIXEL_BLACK) return FLAG_BLACK;
        return '0;
    endfunction

    function automatic logic [PIXEL_W-1:0] window_verdict(int unsigned w, int unsigned h);
        bit          any_hit;
        bit          all_hit;
        bit          off_image;
        bit          in_frame;
        flags_t      kind;
        flags_t      seen;
        int unsigned r;
        int unsigned c;
        any_hit   = 1'b0;
        all_hit   = 1'b1;
        off_image = 1'b0;
        for (int i = 0; i < 9; i++) begin
            kind = cfg_cells[2*i +: 2];
            if (kind != KIND_WHITE && kind != KIND_BLACK) continue;
            r = i / 3;
            c = i % 3;
            in_frame = !((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                         (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w));
            seen = in_frame ? win[c][r] : FLAG_BLACK;
            if ((seen & kind) != '0) any_hit = 1'b1;
            else all_hit = 1'b0;
            if (!in_frame) off_image = 1'b1;
        end
        if (cfg_mode == MODE_DILATE) return any_hit ? PIXEL_WHITE : PIXEL_BLACK;
        if (cfg_mode == MODE_ERODE) return all_hit ? PIXEL_WHITE : PIXEL_BLACK;
        return (all_hit && !off_image) ? PIXEL_WHITE : PIXEL_BLACK;
    endfunction

    task automatic morph_step(input logic [PIXEL_W-1:0] pix, input logic drain);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        flags_t      f;
        flags_t      top;
        flags_t      mid;
        bit          emit;
        out_word_t   res;
        w = span_cols();
        h = span_rows();
        if (drain && in_row < h) return;
        f   = (in_row < h) ? pixel_flags(pix) : FLAG_BLACK;
        col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
        top = older_row[col];
        mid = newer_row[col];
        older_row[col] = mid;
        newer_row[col] = f;
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = f;
        emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;
        res.result_pixel = window_verdict(w, h);
        res.frame_last   = (out_row + 1 >= h) && (out_col + 1 >= w);
        pending_results.push_back(res);
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        if (res.frame_last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return PIXEL_BLACK;
        if (pick < 8) return PIXEL_WHITE;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = value[IMG_W_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = value[IMG_H_W-1:0];
            end
            REG_OPERATION_MODE: begin
                cfg_mode = value[MODE_W-1:0];
            end
            default: begin
                cfg_cells = value[KINDS_W-1:0];
            end
        endcase
    endtask

    task automatic set_config(input logic [IMG_W_W-1:0] w, input logic [IMG_H_W-1:0] h,
                              input logic [MODE_W-1:0] mode, input logic [KINDS_W-1:0] cells);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_OPERATION_MODE, CFG_DATA_W'(mode));
        write_reg(REG_CELL_KINDS, cells);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one whole frame of the current size, fillers included
    task automatic queue_frame(input bit noisy);
        int unsigned w;
        int unsigned h;
        w = span_cols();
        h = span_rows();
        for (int unsigned k = 0; k < w * h; k++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                pixel_queue.push_back('{random_pixel(), 1'b1});
            pixel_queue.push_back('{random_pixel(), 1'b0});
        end
        for (int unsigned k = 0; k <= w; k++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                pixel_queue.push_back('{random_pixel(), 1'b0});
            else
                pixel_queue.push_back('{8'($urandom_range(0, 255)), 1'b1});
        end
        fed_items += w * h + w + 1;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                in_word_t word;
                word = pixel_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= word.pixel;
                s_axis_tuser  <= word.drain;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // prediction on accepted input words, checking of result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                morph_step(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, actual pixel %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    out_word_t want;
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.result_pixel) begin
                        mismatch_count++;
                        $display("%0t: result_pixel expected %0d actual %0d",
                                 $time, want.result_pixel, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.frame_last) begin
                        mismatch_count++;
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.frame_last, m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned        random_base;
        int unsigned        pick;
        logic [IMG_W_W-1:0] wv;
        logic [IMG_H_W-1:0] hv;
        logic [MODE_W-1:0]  mv;
        logic [KINDS_W-1:0] cv;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-white erode, stray filler up front, a pixel among the fillers
        set_config(12'd3, 16'd3, MODE_ERODE, 18'h15555);
        pixel_queue.push_back('{8'd9, 1'b1});
        repeat (4) pixel_queue.push_back('{PIXEL_WHITE, 1'b0});
        pixel_queue.push_back('{PIXEL_BLACK, 1'b0});
        repeat (3) pixel_queue.push_back('{PIXEL_WHITE, 1'b0});
        pixel_queue.push_back('{8'd128, 1'b0});
        pixel_queue.push_back('{8'd0, 1'b1});
        pixel_queue.push_back('{8'd255, 1'b1});
        pixel_queue.push_back('{8'd7, 1'b0});
        pixel_queue.push_back('{8'd0, 1'b1});
        wait_idle();

        // zero width and height, spare mode code, all-black cells
        set_config(12'd0, 16'd0, MODE_SPARE, 18'h2AAAA);
        pixel_queue.push_back('{PIXEL_BLACK, 1'b0});
        pixel_queue.push_back('{PIXEL_WHITE, 1'b0});
        pixel_queue.push_back('{8'd85, 1'b1});
        wait_idle();

        // dilate with no active cell
        set_config(12'd2, 16'd2, MODE_DILATE, 18'h00000);
        pixel_queue.push_back('{8'd128, 1'b0});
        pixel_queue.push_back('{8'd1, 1'b0});
        pixel_queue.push_back('{8'd254, 1'b0});
        pixel_queue.push_back('{PIXEL_WHITE, 1'b0});
        repeat (3) pixel_queue.push_back('{8'd170, 1'b1});
        wait_idle();

        // hit-or-miss with every cell inactive
        set_config(12'd1, 16'd2, MODE_HIT_MISS, 18'h3FFFF);
        pixel_queue.push_back('{PIXEL_BLACK, 1'b0});
        pixel_queue.push_back('{PIXEL_WHITE, 1'b0});
        repeat (2) pixel_queue.push_back('{8'd0, 1'b1});
        wait_idle();

        // long receiver stall while the sender keeps offering words
        set_config(12'd8, 16'd8, MODE_HIT_MISS, 18'($urandom));
        hold_armed = 1'b1;
        queue_frame(1'b0);
        wait_idle();

        random_base = fed_items;
        while (fed_items - random_base < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) wv = IMG_W_W'($urandom_range(1, 8));
            else if (pick < 9) wv = IMG_W_W'($urandom_range(9, 24));
            else wv = '0;
            hv = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            mv = MODE_W'($urandom_range(0, 3));
            cv = KINDS_W'($urandom);
            if ($urandom_range(0, 2) == 0) cv = cv & 18'($urandom);
            calm = (fed_items - random_base > RANDOM_WORDS - 300) || $urandom_range(0, 4) == 0;
            set_config(wv, hv, mv, cv);
            repeat ($urandom_range(1, 3)) begin
                queue_frame($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                    pixel_queue.push_back('{random_pixel(), 1'b1});
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
